/* hw/rtl/bpfa_pkg.sv */
// Package for the bitmap page frame allocator.
// Holds map geometry, command codes, sequencer states and shared types.
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;
  localparam int MaxFrames  = 32768;
  localparam int WordBits   = 64;
  localparam int NumWords   = MaxFrames / WordBits;
  localparam int WordAw     = $clog2(NumWords);
  localparam int BitAw      = $clog2(WordBits);
  localparam int PageAw     = $clog2(MaxFrames);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_ALLOC     = 3'd1,
    CMD_FREE      = 3'd2,
    CMD_RESERVE   = 3'd3,
    CMD_UNRESERVE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MANAGED  = 2'd0,
    REG_START_FREE = 2'd1,
    REG_START_RSV  = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SET_RD,
    ST_SET_WR,
    ST_RUN_RD,
    ST_RUN_WR,
    ST_DONE
  } state_t;

  // memory request from the sequencer to the map store
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [WordAw-1:0] addr;
    word_t             wdata;
  } map_req_t;
endpackage
`default_nettype wire

/* hw/rtl/bpfa_if.sv */
// Valid/ready channel interfaces for the allocator.
// Depends on nothing but widths of the work fields.
`timescale 1ns / 1ps
`default_nettype none
interface bpfa_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [14:0] first_page;
  logic [15:0] page_count;
  modport source (output valid, command, first_page, page_count, input ready);
  modport sink   (input valid, command, first_page, page_count, output ready);
endinterface

interface bpfa_res_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [14:0] run_start;
  logic [15:0] free_count;
  logic [15:0] used_count;
  logic [15:0] reserved_count;
  modport source (output valid, ok, run_start, free_count, used_count, reserved_count,
                  input ready);
  modport sink   (input valid, ok, run_start, free_count, used_count, reserved_count,
                  output ready);
endinterface

interface bpfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bpfa_map_ram.sv */
// Busy bitmap store: one 64-bit word per address, registered read.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_map_ram
  import bpfa_pkg::*;
(
  input  wire logic     clk,
  input  wire map_req_t req,
  output word_t         rdata
);
  word_t mem [NumWords];

  always_ff @(posedge clk) begin
    if (req.wr) mem[req.addr] <= req.wdata;
    if (req.rd) rdata <= mem[req.addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/bpfa_seq.sv */
// Command sequencer: scans the bitmap page by page and updates runs word by word.
// Depends on bpfa_pkg; drives the request into bpfa_map_ram.
`timescale 1ns / 1ps
`default_nettype none
module bpfa_seq
  import bpfa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpfa_cmd_if.sink   in_ch,
  bpfa_res_if.source out_ch,
  input  wire logic [15:0] managed_pages,
  input  wire logic [15:0] start_free,
  input  wire logic [15:0] start_rsv,
  output map_req_t   req,
  input  wire word_t rdata
);
  state_t st_r, st_nxt;
  logic [WordAw:0]   clr_r, clr_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [PageAw:0]   pg_r, pg_nxt;      // current page (may equal limit)
  logic [PageAw:0]   end_r, end_nxt;    // exclusive end of run
  logic [16:0]       run_r, run_nxt;
  logic [PageAw:0]   rfirst_r, rfirst_nxt;
  logic [15:0]       cnt_r, cnt_nxt;
  logic [15:0]       fc_r, fc_nxt, uc_r, uc_nxt, rc_r, rc_nxt;
  logic              ok_r, ok_nxt;
  logic [14:0]       rs_r, rs_nxt;

  logic [PageAw:0] limit;
  assign limit = (managed_pages > 16'(MaxFrames)) ? (PageAw+1)'(MaxFrames)
                                                  : managed_pages[PageAw:0];

  // per-word masks for run update
  logic [PageAw:0]   wbase;
  word_t             mask, chg, wnew;
  logic [BitAw:0]    nchg;
  logic [PageAw:0]   wlim;
  logic [16:0]       dlt;

  always_comb begin
    wbase = {pg_r[PageAw:BitAw], {BitAw{1'b0}}};
    for (int b = 0; b < WordBits; b++)
      mask[b] = ((wbase + (PageAw+1)'(b)) >= pg_r) && ((wbase + (PageAw+1)'(b)) < end_r);
    if (cmd_r == CMD_RESERVE || cmd_r == CMD_ALLOC) begin
      chg = mask & ~rdata;
      wnew = rdata | mask;
    end else begin
      chg = mask & rdata;
      wnew = rdata & ~mask;
    end
    nchg = (BitAw+1)'($countones(chg));
    wlim = wbase + (PageAw+1)'(WordBits);
  end

  // scan evaluates one bit per cycle within the loaded word
  logic bit_busy;
  assign bit_busy = rdata[pg_r[BitAw-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      clr_r <= '0;
      fc_r <= '0; uc_r <= '0; rc_r <= '0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      fc_r <= fc_nxt; uc_r <= uc_nxt; rc_r <= rc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; pg_r <= pg_nxt; end_r <= end_nxt; run_r <= run_nxt;
    rfirst_r <= rfirst_nxt; cnt_r <= cnt_nxt; ok_r <= ok_nxt; rs_r <= rs_nxt;
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; cmd_nxt = cmd_r; pg_nxt = pg_r; end_nxt = end_r;
    run_nxt = run_r; rfirst_nxt = rfirst_r; cnt_nxt = cnt_r;
    fc_nxt = fc_r; uc_nxt = uc_r; rc_nxt = rc_r; ok_nxt = ok_r; rs_nxt = rs_r;
    req = '0;
    dlt = 17'(nchg);
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    case (st_r)
      ST_CLEAR, ST_INIT: begin
        req.wr = 1'b1;
        req.addr = clr_r[WordAw-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (WordAw+1)'(NumWords - 1)) begin
          clr_nxt = '0;
          st_nxt = (st_r == ST_CLEAR) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt = cmd_t'(in_ch.command);
          cnt_nxt = in_ch.page_count;
          ok_nxt = 1'b1; rs_nxt = '0; run_nxt = '0;
          pg_nxt = '0; rfirst_nxt = '0;
          case (in_ch.command)
            CMD_INIT: begin
              fc_nxt = start_free; uc_nxt = '0; rc_nxt = start_rsv;
              st_nxt = ST_INIT;
            end
            CMD_ALLOC: begin
              if (in_ch.page_count == '0 || limit == '0) begin
                ok_nxt = 1'b0; st_nxt = ST_DONE;
              end else st_nxt = ST_SCAN_RD;
            end
            CMD_FREE, CMD_RESERVE, CMD_UNRESERVE: begin
              pg_nxt = {1'b0, in_ch.first_page};
              if ({2'b0, in_ch.first_page} + 17'(in_ch.page_count) > 17'(limit))
                end_nxt = limit;
              else
                end_nxt = (PageAw+1)'({1'b0, in_ch.first_page} + in_ch.page_count);
              st_nxt = ({1'b0, in_ch.first_page} >= limit || in_ch.page_count == '0)
                       ? ST_DONE : ST_RUN_RD;
            end
            default: begin
              ok_nxt = 1'b0; st_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN_RD: begin
        req.rd = 1'b1;
        req.addr = pg_r[PageAw-1:BitAw];
        st_nxt = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        // advance one page per cycle; reload word at its boundary
        if (bit_busy) run_nxt = '0;
        else begin
          if (run_r == '0) rfirst_nxt = pg_r;
          run_nxt = run_r + 1'b1;
        end
        pg_nxt = pg_r + 1'b1;
        if (!bit_busy && run_r + 1'b1 == {1'b0, cnt_r}) begin
          pg_nxt = bit_busy ? rfirst_r : (run_r == '0 ? pg_r : rfirst_r);
          end_nxt = pg_r + 1'b1;
          st_nxt = ST_RUN_RD;
        end else if (pg_r + 1'b1 >= limit) begin
          ok_nxt = 1'b0; st_nxt = ST_DONE;
        end else if (pg_r[BitAw-1:0] == '1) st_nxt = ST_SCAN_RD;
      end
      ST_RUN_RD: begin
        req.rd = 1'b1;
        req.addr = pg_r[PageAw-1:BitAw];
        st_nxt = ST_RUN_WR;
      end
      ST_RUN_WR: begin
        req.wr = 1'b1;
        req.addr = pg_r[PageAw-1:BitAw];
        req.wdata = wnew;
        case (cmd_r)
          CMD_ALLOC: begin
            rs_nxt = rfirst_r[14:0];
          end
          CMD_RESERVE: begin
            rc_nxt = (17'(rc_r) + dlt > 17'hFFFF) ? 16'hFFFF : 16'(17'(rc_r) + dlt);
            fc_nxt = (fc_r > 16'(dlt)) ? fc_r - 16'(dlt) : '0;
          end
          CMD_FREE: begin
            uc_nxt = (uc_r > 16'(dlt)) ? uc_r - 16'(dlt) : '0;
            fc_nxt = (17'(fc_r) + dlt > 17'hFFFF) ? 16'hFFFF : 16'(17'(fc_r) + dlt);
          end
          default: begin
            rc_nxt = (rc_r > 16'(dlt)) ? rc_r - 16'(dlt) : '0;
            fc_nxt = (17'(fc_r) + dlt > 17'hFFFF) ? 16'hFFFF : 16'(17'(fc_r) + dlt);
          end
        endcase
        pg_nxt = wlim;
        if (wlim >= end_r) begin
          if (cmd_r == CMD_ALLOC) begin
            uc_nxt = (17'(uc_r) + 17'(cnt_r) > 17'hFFFF) ? 16'hFFFF : uc_r + cnt_r;
            fc_nxt = (fc_r > cnt_r) ? fc_r - cnt_r : '0;
          end
          st_nxt = ST_DONE;
        end else st_nxt = ST_RUN_RD;
      end
      ST_DONE: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.ok = ok_r;
  assign out_ch.run_start = rs_r;
  assign out_ch.free_count = fc_r;
  assign out_ch.used_count = uc_r;
  assign out_ch.reserved_count = rc_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> st_r == ST_IDLE) else $error("ready outside idle");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready with result pending");
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.rd && req.wr)) else $error("map read and write together");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ok) |-> out_ch.run_start == '0)
    else $error("failed item with run start");
endmodule
`default_nettype wire

/* hw/rtl/bitmap_page_frame_allocator_unit.sv */
// Bitmap page frame allocator, first fit.
// Channels: in_ (command, first_page, page_count), out_ (ok, run_start and
// the free, used and reserved counters), cfg_ (index, data register writes).
// All channels transfer when valid and ready are high at a rising edge.
// One command at a time: in_ready is high only while idle.
// The bitmap is 512 words of 64 bits in a single-port memory.
// Init clears every map word, then gives the result. Allocate scans
// page by page, with a word read at each 64-page boundary, up to the
// run's end, then reads and writes back each word of the run.
// Free, reserve and unreserve read and write back each map word the run touches.
// After reset a pass clears all 512 words before in_ready rises; config
// writes are taken at all times. The result holds on out_ until out_ready.
// Registers come up as managed_pages 32768, start counts 0.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator_unit
  import bpfa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpfa_cmd_if.sink   in_ch,
  bpfa_res_if.source out_ch,
  bpfa_cfg_if.sink   cfg_ch
);
  logic [15:0] managed_r, sfree_r, srsv_r;
  map_req_t    req;
  word_t       rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r <= 16'd32768; sfree_r <= '0; srsv_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MANAGED:    managed_r <= cfg_ch.data;
        REG_START_FREE: sfree_r   <= cfg_ch.data;
        REG_START_RSV:  srsv_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  bpfa_seq u_seq (
    .clk, .rst_n, .in_ch, .out_ch,
    .managed_pages(managed_r), .start_free(sfree_r), .start_rsv(srsv_r),
    .req, .rdata
  );

  bpfa_map_ram u_ram (.clk, .req, .rdata);
endmodule
`default_nettype wire
